// ===== hw/rtl/ilha_pkg.sv =====
// Shared types and constants of the implicit-list heap allocator.
// Holds the datapath command codes, the status flag bundle and the result codes.
// No dependencies.
package ilha_pkg;

  localparam int unsigned HEAP_BYTES_DEF  = 65536;
  localparam int unsigned CHUNK_BYTES_DEF = 4096;
  localparam int unsigned STORE_WORDS     = 16384;
  localparam int unsigned STORE_BYTES     = 65536;
  localparam int unsigned TAG_W           = 32;
  localparam int unsigned AW              = 18;   // byte address / size arithmetic
  localparam int unsigned TOP_W           = 17;
  localparam int unsigned MIN_SPLIT       = 16;
  localparam int unsigned FIRST_PAYLOAD   = 16;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NULL      = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    C_NOP, C_LATCH, C_DISP, C_B0, C_B1, C_B2, C_B3,
    C_EXCHK, C_EXOLD, C_EXW2, C_EXW3,
    C_COR1, C_COR2, C_COR3, C_COR4, C_COW1, C_COW2, C_COW3,
    C_WCHK, C_WRD, C_PLISS, C_PLH, C_PLS1, C_PLS2,
    C_FRISS, C_FRH, C_FRW2, C_NRD, C_NWR
  } cmd_e;

  typedef struct packed {
    logic ready;       // heap built
    logic is_free;     // latched opcode is free
    logic null_req;    // zero size or malformed free address
    logic ext_fail;    // growth does not fit
    logic prev_set;    // header of current block has previous-allocated bit
    logic next_alloc;  // next block allocated (valid in C_COR3)
    logic walk_end;    // walk pointer ran past the heap
    logic tag_bad;     // walked tag has zero or oversize size
    logic hit;         // walk found its block
    logic past;        // walk passed the free target
    logic tag_alloc;   // walked tag allocated
    logic split;       // placement leaves a splittable remainder
    logic bp_zero;     // growth returned no block
  } dp_stat_t;

endpackage

// ===== hw/rtl/ilha_ram.sv =====
// Generic single-port RAM with registered read.
// One access per cycle; no dependencies.
module ilha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and read at the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hw/rtl/ilha_datapath.sv =====
// Datapath of the heap allocator: request registers, walk and tag arithmetic,
// heap top, and the tag store RAM. Depends on ilha_pkg and ilha_ram.
module ilha_datapath #(
  parameter int unsigned HEAP_BYTES  = ilha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES = ilha_pkg::CHUNK_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ilha_pkg::cmd_e        cmd_i,
  input  logic                  opcode_i,
  input  logic [15:0]           request_size_i,
  input  logic [15:0]           free_address_i,
  output ilha_pkg::dp_stat_t    stat_o,
  output logic [15:0]           result_address_o
);
  import ilha_pkg::*;

  localparam int unsigned LIMIT  = (HEAP_BYTES < STORE_BYTES) ? HEAP_BYTES : STORE_BYTES;
  localparam int unsigned CHUNK8 = ((CHUNK_BYTES + 7) / 8) * 8;
  localparam logic [AW-1:0]    LIMIT_A  = AW'(LIMIT);
  localparam logic [AW-1:0]    CHUNK_A  = AW'(CHUNK8);
  localparam logic [TAG_W-1:0] LIMIT_T  = TAG_W'(LIMIT);
  localparam int unsigned      IDX_W    = $clog2(STORE_WORDS);

  logic             op_q;
  logic [15:0]      rsize_q, faddr_q, res_q;
  logic [AW-1:0]    p_q, bp_q, cb_q, size_q, asize_q, esize_q, nh_size_q;
  logic             nh_alloc_q, hprev_q;
  logic [TOP_W-1:0] top_q;
  logic             ready_q;

  logic [TAG_W-1:0] rdata;
  logic [AW-1:0]    rsz;        // size field of read tag
  logic [AW-1:0]    asize_d, esize_d, psum, top_a;
  logic [AW-1:0]    maddr;
  logic             mwe;
  logic [TAG_W-1:0] mwdata;

  assign rsz   = {rdata[AW-1:3], 3'b000};
  assign top_a = AW'(top_q);

  // block need and growth size for the latched request
  always_comb begin
    if (rsize_q <= 16'd4) begin
      asize_d = AW'(8);
    end else begin
      asize_d = (AW'(rsize_q) + AW'(11)) & ~AW'(7);
    end
    esize_d = (asize_d > CHUNK_A) ? asize_d : CHUNK_A;
  end

  assign psum = size_q + rsz;

  // status flags toward the controller
  always_comb begin
    stat_o            = '0;
    stat_o.ready      = ready_q;
    stat_o.is_free    = op_q;
    stat_o.null_req   = op_q ? (faddr_q == 16'd0 || faddr_q[2:0] != 3'd0 ||
                                faddr_q < 16'(FIRST_PAYLOAD))
                             : (rsize_q == 16'd0);
    stat_o.ext_fail   = (top_a > LIMIT_A) || (esize_q > (LIMIT_A - top_a));
    stat_o.prev_set   = hprev_q;
    stat_o.next_alloc = rdata[0];
    stat_o.walk_end   = (p_q - AW'(4)) >= top_a;
    stat_o.tag_bad    = (rdata[TAG_W-1:3] == '0) ||
                        ({rdata[TAG_W-1:3], 3'b000} > LIMIT_T);
    stat_o.hit        = op_q ? (p_q == AW'(faddr_q))
                             : (!rdata[0] && rsz >= asize_q);
    stat_o.past       = p_q > AW'(faddr_q);
    stat_o.tag_alloc  = rdata[0];
    stat_o.split      = (rsz - asize_q) >= AW'(MIN_SPLIT);
    stat_o.bp_zero    = (bp_q == '0);
  end

  // tag store address and write data
  always_comb begin
    maddr  = '0;
    mwe    = 1'b0;
    mwdata = '0;
    case (cmd_i)
      C_B0:    begin maddr = AW'(0);  mwe = 1'b1; mwdata = '0; end
      C_B1:    begin maddr = AW'(4);  mwe = 1'b1; mwdata = TAG_W'(11); end
      C_B2:    begin maddr = AW'(8);  mwe = 1'b1; mwdata = TAG_W'(9); end
      C_B3:    begin maddr = AW'(12); mwe = 1'b1; mwdata = TAG_W'(3); end
      C_EXCHK: maddr = top_a - AW'(4);
      C_EXOLD: begin
        maddr = bp_q - AW'(4); mwe = 1'b1;
        mwdata = TAG_W'(esize_q) | (rdata & TAG_W'(2));
      end
      C_EXW2:  begin maddr = bp_q + esize_q - AW'(8); mwe = 1'b1; mwdata = TAG_W'(esize_q); end
      C_EXW3:  begin maddr = bp_q + esize_q - AW'(4); mwe = 1'b1; mwdata = TAG_W'(1); end
      C_COR1:  maddr = bp_q - AW'(4);
      C_COR2:  maddr = bp_q + rsz - AW'(4);
      C_COR3:  maddr = bp_q - AW'(8);
      C_COR4:  maddr = bp_q - rsz - AW'(4);
      C_COW1:  begin maddr = cb_q - AW'(4); mwe = 1'b1; mwdata = TAG_W'(size_q) | TAG_W'(2); end
      C_COW2:  begin maddr = cb_q + size_q - AW'(8); mwe = 1'b1; mwdata = TAG_W'(size_q); end
      C_COW3:  begin
        maddr = cb_q - AW'(4); mwe = 1'b1;
        mwdata = TAG_W'(size_q) | (rdata & TAG_W'(2));
      end
      C_WCHK:  maddr = p_q - AW'(4);
      C_PLISS, C_FRISS: maddr = bp_q - AW'(4);
      C_PLH:   begin
        maddr = bp_q - AW'(4); mwe = 1'b1;
        mwdata = TAG_W'(stat_o.split ? asize_q : rsz) | TAG_W'(1) | (rdata & TAG_W'(2));
      end
      C_PLS1:  begin
        maddr = bp_q + asize_q - AW'(4); mwe = 1'b1;
        mwdata = TAG_W'(size_q - asize_q) | TAG_W'(2);
      end
      C_PLS2:  begin
        maddr = bp_q + size_q - AW'(8); mwe = 1'b1;
        mwdata = TAG_W'(size_q - asize_q);
      end
      C_FRH:   begin
        maddr = bp_q - AW'(4); mwe = 1'b1;
        mwdata = TAG_W'(rsz) | (rdata & TAG_W'(2));
      end
      C_FRW2:  begin maddr = bp_q + size_q - AW'(8); mwe = 1'b1; mwdata = TAG_W'(size_q); end
      C_NRD:   maddr = bp_q + size_q - AW'(4);
      C_NWR:   begin
        maddr = bp_q + size_q - AW'(4); mwe = 1'b1;
        mwdata = op_q ? (rdata & ~TAG_W'(2)) : (rdata | TAG_W'(2));
      end
      default: maddr = '0;
    endcase
  end

  // control state of the heap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= '0;
      ready_q <= 1'b0;
    end else begin
      if (cmd_i == C_B3) begin
        top_q   <= TOP_W'(FIRST_PAYLOAD);
        ready_q <= 1'b1;
      end else if (cmd_i == C_EXW3) begin
        top_q   <= top_q + TOP_W'(esize_q);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      C_LATCH: begin
        op_q    <= opcode_i;
        rsize_q <= request_size_i;
        faddr_q <= free_address_i;
        res_q   <= '0;
      end
      C_DISP: begin
        asize_q <= asize_d;
        esize_q <= (esize_d + AW'(7)) & ~AW'(7);
        p_q     <= AW'(8);
      end
      C_B3:    esize_q <= CHUNK_A;
      C_EXCHK: bp_q <= stat_o.ext_fail ? '0 : top_a;
      C_COR1:  cb_q <= bp_q;
      C_COR2: begin
        hprev_q <= rdata[1];
        size_q  <= rsz;
      end
      C_COR3: begin
        nh_alloc_q <= rdata[0];
        nh_size_q  <= rsz;
        if (hprev_q && !rdata[0]) begin
          size_q <= psum;
        end
      end
      C_COR4: begin
        cb_q   <= bp_q - rsz;
        size_q <= nh_alloc_q ? psum : (psum + nh_size_q);
      end
      C_COW2:  bp_q <= cb_q;
      C_WRD: begin
        bp_q <= p_q;
        p_q  <= p_q + rsz;
      end
      C_PLISS: res_q <= bp_q[15:0];
      C_PLH, C_FRH: size_q <= rsz;
      default: ;
    endcase
  end

  assign result_address_o = res_q;

  ilha_ram #(
    .WIDTH (TAG_W),
    .DEPTH (STORE_WORDS)
  ) u_tags (
    .clk_i   (clk_i),
    .we_i    (mwe),
    .addr_i  (maddr[IDX_W+1:2]),
    .wdata_i (mwdata),
    .rdata_o (rdata)
  );

endmodule

// ===== hw/rtl/ilha_ctrl.sv =====
// Controller of the heap allocator: one-hot sequencer over build, walk,
// growth, coalescing, placement and free. Depends on ilha_pkg.
module ilha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ilha_pkg::dp_stat_t  stat_i,
  output ilha_pkg::cmd_e      cmd_o,
  output logic                done_o,
  output logic [1:0]          status_o
);
  import ilha_pkg::*;

  typedef enum logic [29:0] {
    S_IDLE  = 30'd1 << 0,  S_DISP  = 30'd1 << 1,  S_B0    = 30'd1 << 2,
    S_B1    = 30'd1 << 3,  S_B2    = 30'd1 << 4,  S_B3    = 30'd1 << 5,
    S_EXCHK = 30'd1 << 6,  S_EXOLD = 30'd1 << 7,  S_EXW2  = 30'd1 << 8,
    S_EXW3  = 30'd1 << 9,  S_COR1  = 30'd1 << 10, S_COR2  = 30'd1 << 11,
    S_COR3  = 30'd1 << 12, S_COR4  = 30'd1 << 13, S_COW1  = 30'd1 << 14,
    S_COW2  = 30'd1 << 15, S_COW3  = 30'd1 << 16, S_RET   = 30'd1 << 17,
    S_WCHK  = 30'd1 << 18, S_WRD   = 30'd1 << 19, S_PLISS = 30'd1 << 20,
    S_PLH   = 30'd1 << 21, S_PLS1  = 30'd1 << 22, S_PLS2  = 30'd1 << 23,
    S_FRISS = 30'd1 << 24, S_FRH   = 30'd1 << 25, S_FRW2  = 30'd1 << 26,
    S_NRD   = 30'd1 << 27, S_NWR   = 30'd1 << 28, S_FIN   = 30'd1 << 29
  } state_e;

  typedef enum logic [1:0] {
    R_BUILD, R_GROW, R_FREE
  } ret_e;

  state_e  state_q, state_d;
  ret_e    ret_q, ret_d;
  status_e st_q, st_d;

  // next state and datapath command
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    st_d    = st_q;
    cmd_o   = C_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = C_LATCH;
          state_d = stat_i.ready ? S_DISP : S_B0;
        end
      end
      S_B0: begin cmd_o = C_B0; state_d = S_B1; end
      S_B1: begin cmd_o = C_B1; state_d = S_B2; end
      S_B2: begin cmd_o = C_B2; state_d = S_B3; end
      S_B3: begin cmd_o = C_B3; state_d = S_EXCHK; ret_d = R_BUILD; end
      S_DISP: begin
        cmd_o = C_DISP;
        if (stat_i.null_req) begin
          st_d = ST_NULL; state_d = S_FIN;
        end else begin
          state_d = S_WCHK;
        end
      end
      S_EXCHK: begin
        cmd_o   = C_EXCHK;
        state_d = stat_i.ext_fail ? S_RET : S_EXOLD;
      end
      S_EXOLD: begin cmd_o = C_EXOLD; state_d = S_EXW2; end
      S_EXW2:  begin cmd_o = C_EXW2;  state_d = S_EXW3; end
      S_EXW3:  begin cmd_o = C_EXW3;  state_d = S_COR1; end
      S_COR1:  begin cmd_o = C_COR1;  state_d = S_COR2; end
      S_COR2:  begin cmd_o = C_COR2;  state_d = S_COR3; end
      S_COR3: begin
        cmd_o = C_COR3;
        if (!stat_i.prev_set) begin
          state_d = S_COR4;
        end else if (stat_i.next_alloc) begin
          state_d = S_RET;
        end else begin
          state_d = S_COW1;
        end
      end
      S_COR4:  begin cmd_o = C_COR4; state_d = S_COW3; end
      S_COW1:  begin cmd_o = C_COW1; state_d = S_COW2; end
      S_COW3:  begin cmd_o = C_COW3; state_d = S_COW2; end
      S_COW2:  begin cmd_o = C_COW2; state_d = S_RET; end
      // return from growth or merge
      S_RET: begin
        unique case (ret_q)
          R_BUILD: state_d = S_DISP;
          R_GROW: begin
            if (stat_i.bp_zero) begin
              st_d = ST_EXHAUSTED; state_d = S_FIN;
            end else begin
              state_d = S_PLISS;
            end
          end
          default: begin st_d = ST_DONE; state_d = S_FIN; end
        endcase
      end
      S_WCHK: begin
        cmd_o = C_WCHK;
        if (stat_i.walk_end) begin
          if (stat_i.is_free) begin
            st_d = ST_NULL; state_d = S_FIN;
          end else begin
            ret_d = R_GROW; state_d = S_EXCHK;
          end
        end else begin
          state_d = S_WRD;
        end
      end
      S_WRD: begin
        cmd_o   = C_WRD;
        state_d = S_WCHK;
        if (stat_i.tag_bad) begin
          if (stat_i.is_free) begin
            st_d = ST_NULL; state_d = S_FIN;
          end else begin
            ret_d = R_GROW; state_d = S_EXCHK;
          end
        end else if (!stat_i.is_free) begin
          if (stat_i.hit) begin
            state_d = S_PLISS;
          end
        end else if (stat_i.hit) begin
          if (stat_i.tag_alloc) begin
            state_d = S_FRISS;
          end else begin
            st_d = ST_NULL; state_d = S_FIN;
          end
        end else if (stat_i.past) begin
          st_d = ST_NULL; state_d = S_FIN;
        end
      end
      S_PLISS: begin cmd_o = C_PLISS; state_d = S_PLH; end
      S_PLH: begin
        cmd_o   = C_PLH;
        state_d = stat_i.split ? S_PLS1 : S_NRD;
      end
      S_PLS1:  begin cmd_o = C_PLS1; state_d = S_PLS2; end
      S_PLS2:  begin cmd_o = C_PLS2; st_d = ST_DONE; state_d = S_FIN; end
      S_FRISS: begin cmd_o = C_FRISS; state_d = S_FRH; end
      S_FRH:   begin cmd_o = C_FRH; state_d = S_FRW2; end
      S_FRW2:  begin cmd_o = C_FRW2; state_d = S_NRD; end
      S_NRD:   begin cmd_o = C_NRD; state_d = S_NWR; end
      S_NWR: begin
        cmd_o = C_NWR;
        if (stat_i.is_free) begin
          ret_d = R_FREE; state_d = S_COR1;
        end else begin
          st_d = ST_DONE; state_d = S_FIN;
        end
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= R_BUILD;
      st_q    <= ST_DONE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      st_q    <= st_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = (state_q == S_FIN);
  assign status_o = st_q;

endmodule

// ===== hw/rtl/implicit_list_heap_allocator_core.sv =====
// Top level of the implicit-list heap allocator.
// Depends on ilha_pkg, ilha_ctrl and ilha_datapath.
//
// Pulse start while busy is low to hand in one allocate or free item; busy
// stays high until the result, and done_o is high for exactly one cycle with
// result_address_o and status_o valid. The receiver cannot stall, so capture
// the result on that cycle. The first-fit search (and the validity walk of a
// free) reads one boundary tag per block walked through the single tag-store
// port. Placement, a free and a heap growth each add their own tag-store
// steps, and the very first item builds the heap first and then grows it once.
module implicit_list_heap_allocator_core #(
  parameter int unsigned HEAP_BYTES  = ilha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES = ilha_pkg::CHUNK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] free_address_i,
  output logic        done_o,
  output logic [15:0] result_address_o,
  output logic [1:0]  status_o
);
  import ilha_pkg::*;

  cmd_e     cmd;
  dp_stat_t stat;

  ilha_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .done_o   (done_o),
    .status_o (status_o)
  );

  ilha_datapath #(
    .HEAP_BYTES  (HEAP_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .opcode_i         (opcode_i),
    .request_size_i   (request_size_i),
    .free_address_i   (free_address_i),
    .stat_o           (stat),
    .result_address_o (result_address_o)
  );

endmodule

// ===== tb/implicit_list_heap_allocator_core_test.sv =====
// Self-checking bench for implicit_list_heap_allocator_core: allocate and free items are
// checked against a tag-level allocator predictor. Depends on ilha_pkg and the core RTL.
module implicit_list_heap_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ilha_pkg::*;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam int unsigned CHUNK  = 4096;
  localparam int unsigned LIMIT  = 65536;
  localparam int unsigned BIT_AL = 32'h1;
  localparam int unsigned BIT_PV = 32'h2;
  localparam int unsigned SZ_MSK = 32'hFFFF_FFF8;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic        op;
    logic [15:0] size;
    logic [15:0] addr;
  } heap_req_t;

  typedef struct packed {
    logic [15:0] addr;
    status_e     status;
  } heap_rsp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        opcode_i;
  logic [15:0] request_size_i;
  logic [15:0] free_address_i;
  logic        done_o;
  logic [15:0] result_address_o;
  logic [1:0]  status_o;

  implicit_list_heap_allocator_core u_dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .request_size_i, .free_address_i,
    .done_o, .result_address_o, .status_o
  );

  // Predictor state: boundary tags, heap top and build flag
  int unsigned tags [16384];
  int unsigned top_q;
  bit          built_q;

  heap_req_t   pending_q [$];
  heap_rsp_t   expected_q [$];
  int unsigned live_q [$];      // payloads the predictor holds allocated
  int          errors;
  int          results;
  int          n_alloc, n_free, n_exh, n_null;
  int          idle_cycles;
  bit          stim_done;

  function automatic int unsigned tag_rd(int unsigned b);
    return tags[(b >> 2) & 16383];
  endfunction

  function automatic void tag_wr(int unsigned b, int unsigned v);
    tags[(b >> 2) & 16383] = v;
  endfunction

  function automatic int unsigned merge_free(int unsigned bp);
    int unsigned h, sz, nh, psz, pbp, ph;
    bit nxt;
    h = tag_rd(bp - 4);
    sz = h & SZ_MSK;
    nh = tag_rd(bp + sz - 4);
    nxt = (nh & BIT_AL) != 0;
    if (h & BIT_PV) begin
      if (nxt) return bp;
      sz += nh & SZ_MSK;
      tag_wr(bp - 4, sz | BIT_PV);
      tag_wr(bp + sz - 8, sz);
      return bp;
    end
    psz = tag_rd(bp - 8) & SZ_MSK;
    pbp = bp - psz;
    ph = tag_rd(pbp - 4);
    sz += psz;
    if (!nxt) sz += nh & SZ_MSK;
    tag_wr(pbp - 4, sz | (ph & BIT_PV));
    tag_wr(pbp + sz - 8, sz);
    return pbp;
  endfunction

  function automatic int unsigned grow_heap(int unsigned esz);
    int unsigned bp, old;
    if (top_q > LIMIT || esz > LIMIT - top_q) return 0;
    bp = top_q;
    old = tag_rd(bp - 4);
    tag_wr(bp - 4, esz | (old & BIT_PV));
    tag_wr(bp + esz - 8, esz);
    tag_wr(bp + esz - 4, BIT_AL);
    top_q += esz;
    return merge_free(bp);
  endfunction

  // Walk the block list: first fit when target is zero, else validate target
  function automatic int unsigned walk_list(int unsigned need, int unsigned target);
    int unsigned p, h, sz;
    p = 8;
    forever begin
      if (p - 4 >= top_q) return 0;
      h = tag_rd(p - 4);
      sz = h & SZ_MSK;
      if (sz == 0 || sz > LIMIT) return 0;
      if (target == 0) begin
        if (!(h & BIT_AL) && sz >= need) return p;
      end else if (p == target) begin
        return (h & BIT_AL) ? p : 0;
      end else if (p > target) begin
        return 0;
      end
      p += sz;
    end
  endfunction

  function automatic void place_block(int unsigned bp, int unsigned need);
    int unsigned h, csz, pa, n;
    h = tag_rd(bp - 4);
    csz = h & SZ_MSK;
    pa = h & BIT_PV;
    if (csz - need >= MIN_SPLIT) begin
      tag_wr(bp - 4, need | BIT_AL | pa);
      tag_wr(bp + need - 4, (csz - need) | BIT_PV);
      tag_wr(bp + csz - 8, csz - need);
    end else begin
      n = bp + csz - 4;
      tag_wr(bp - 4, csz | BIT_AL | pa);
      tag_wr(n, tag_rd(n) | BIT_PV);
    end
  endfunction

  function automatic heap_rsp_t serve_request(heap_req_t r);
    heap_rsp_t rsp;
    int unsigned need, bp, h, bsz, n;
    rsp.addr = '0;
    rsp.status = ST_DONE;
    if (!built_q) begin
      tag_wr(0, 0);
      tag_wr(4, 8 | BIT_AL | BIT_PV);
      tag_wr(8, 8 | BIT_AL);
      tag_wr(12, BIT_AL | BIT_PV);
      top_q = FIRST_PAYLOAD;
      built_q = 1;
      void'(grow_heap(CHUNK));
    end
    if (r.op == OP_ALLOC) begin
      if (r.size == 0) begin
        rsp.status = ST_NULL;
      end else begin
        need = (r.size <= 4) ? 8 : ((r.size + 4 + 7) & SZ_MSK);
        bp = walk_list(need, 0);
        if (bp == 0) bp = grow_heap(((need > CHUNK ? need : CHUNK) + 7) & SZ_MSK);
        if (bp == 0) begin
          rsp.status = ST_EXHAUSTED;
        end else begin
          place_block(bp, need);
          rsp.addr = bp[15:0];
        end
      end
    end else begin
      if (r.addr == 0 || r.addr[2:0] != 0 || r.addr < FIRST_PAYLOAD ||
          walk_list(0, r.addr) == 0) begin
        rsp.status = ST_NULL;
      end else begin
        h = tag_rd(r.addr - 4);
        bsz = h & SZ_MSK;
        n = r.addr + bsz - 4;
        tag_wr(r.addr - 4, bsz | (h & BIT_PV));
        tag_wr(r.addr + bsz - 8, bsz);
        tag_wr(n, tag_rd(n) & ~BIT_PV);
        void'(merge_free(r.addr));
      end
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
  endtask

  // Stimulus helpers: predict on queueing so frees can target live blocks
  function automatic void push_req(logic op, int unsigned size, int unsigned addr);
    heap_req_t r;
    heap_rsp_t p;
    int idx;
    r.op = op;
    r.size = size[15:0];
    r.addr = addr[15:0];
    p = serve_request(r);
    if (op == OP_ALLOC && p.status == ST_DONE) live_q.push_back(p.addr);
    if (op == OP_FREE && p.status == ST_DONE) begin
      for (idx = 0; idx < live_q.size(); idx++)
        if (live_q[idx] == addr) begin
          live_q.delete(idx);
          break;
        end
    end
    pending_q.push_back(r);
    expected_q.push_back(p);
  endfunction

  function automatic int unsigned rand_size();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return $urandom_range(1, 64);
    if (k < 85) return $urandom_range(65, 600);
    if (k < 97) return $urandom_range(601, 5000);
    return $urandom_range(0, 65535);
  endfunction

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Fill the item queue: directed part, then random mix
  initial begin : stimulus
    int unsigned i, k, a;
    for (i = 0; i < 16384; i++) tags[i] = 0;
    top_q = 0;
    built_q = 0;
    stim_done = 0;
    push_req(OP_FREE, 0, 0);              // build on a null free
    push_req(OP_ALLOC, 0, 0);             // zero size
    push_req(OP_ALLOC, 1, 0);
    push_req(OP_ALLOC, 4, 0);
    push_req(OP_ALLOC, 5, 0);
    push_req(OP_ALLOC, 12, 0);
    push_req(OP_ALLOC, 5000, 0);          // forces growth
    push_req(OP_ALLOC, 65535, 16'hFFFF);  // exhaustion
    push_req(OP_FREE, 0, 16'h0013);       // misaligned
    push_req(OP_FREE, 0, 8);              // below first payload
    push_req(OP_FREE, 0, 16'hFFF8);       // out of range
    push_req(OP_FREE, 0, live_q[4] + 8);  // inside a block
    a = live_q[1];
    push_req(OP_FREE, 0, a);              // free between allocated neighbors
    push_req(OP_FREE, 0, a);              // double free
    push_req(OP_FREE, 0, live_q[0]);      // merge with next
    push_req(OP_FREE, 0, live_q[0]);      // merge with previous
    push_req(OP_ALLOC, 24000, 0);
    push_req(OP_ALLOC, 30000, 0);         // heap limit
    while (live_q.size() != 0) push_req(OP_FREE, 0, live_q[0]);
    for (i = 0; i < 830; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50 || live_q.size() == 0) begin
        push_req(OP_ALLOC, rand_size(), $urandom_range(0, 65535));
      end else if (k < 90) begin
        push_req(OP_FREE, $urandom_range(0, 65535),
                 live_q[$urandom_range(0, live_q.size() - 1)]);
      end else begin
        push_req(OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
      // keep the heap from filling up for good
      if (live_q.size() > 40) push_req(OP_FREE, 0, live_q[0]);
    end
    stim_done = 1;
  end

  // Driver: bursts of items with random gaps
  int unsigned burst_left, gap_left;
  heap_req_t   cur_req;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      opcode_i <= 1'b0;
      request_size_i <= '0;
      free_address_i <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!(start && !busy) && start) begin
      // hold the item until accepted
    end else if (gap_left != 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_q.size() != 0) begin
      cur_req = pending_q.pop_front();
      start <= 1'b1;
      opcode_i <= cur_req.op;
      request_size_i <= cur_req.size;
      free_address_i <= cur_req.addr;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        burst_left--;
      end
    end else begin
      start <= 1'b0;
    end
  end

  function automatic bit opcode_q_free(heap_rsp_t r);
    return r.addr == 0;
  endfunction

  // Monitor: check each result against the oldest expectation
  always @(posedge clk_i) begin
    heap_rsp_t want;
    if (rst_ni && done_o) begin
      results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", result_address_o, 0);
      end else begin
        want = expected_q.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (result_address_o != want.addr)
          report_mismatch("address", result_address_o, want.addr);
        case (want.status)
          ST_DONE:      if (opcode_q_free(want)) n_free++; else n_alloc++;
          ST_EXHAUSTED: n_exh++;
          default:      n_null++;
        endcase
      end
    end
  end

  // Watchdog and end of run
  initial begin : finish_run
    errors = 0;
    results = 0;
    n_alloc = 0; n_free = 0; n_exh = 0; n_null = 0;
    idle_cycles = 0;
    wait (rst_ni);
    while (!(stim_done && pending_q.size() == 0 && expected_q.size() == 0 && !start)
           && idle_cycles < WATCHDOG) begin
      @(posedge clk_i);
      if (done_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("FAIL");
      $finish;
    end else begin
      repeat (300) @(posedge clk_i);
      $display("%0d results: %0d allocations, %0d frees, %0d exhausted, %0d null",
               results, n_alloc, n_free, n_exh, n_null);
      if (errors == 0 && expected_q.size() == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/ilha_pkg.sv
hw/rtl/ilha_ram.sv
hw/rtl/ilha_datapath.sv
hw/rtl/ilha_ctrl.sv
hw/rtl/implicit_list_heap_allocator_core.sv
tb/implicit_list_heap_allocator_core_test.sv
